@@ rtl/core/srle_pkg.sv @@
// ----------------------------------------------------------------------------
// srle_pkg: shared types and constants for the scanline run-length encoder
// Controller states, command/status groups and packet header codes.
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int RECORD_DEPTH_DEF = 8256;
  localparam int CFG_W            = 13;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic CFG_REG_LINE_WIDTH = 1'b0;  // paddr[2] of line_width

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] SINGLE_CODE = 8'd129;
  localparam logic [7:0] RUN_FLAG    = 8'd128;
  localparam int         MAX_PKT     = 127;
  localparam int         LIT_CUT     = 126;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_TOP, ST_A, ST_B, ST_S1, ST_S2, ST_RCHK,
    ST_RCMP, ST_RW1, ST_RW2, ST_LCHK, ST_LCMP, ST_LLOOK, ST_LHEAD, ST_TERM
  } state_t;

  typedef enum logic [1:0] {RA_AT, RA_AT1, RA_ATN, RA_AT127} raddr_sel_t;

  typedef enum logic [2:0] {
    WS_SINGLE, WS_A, WS_RUN, WS_PIX, WS_V, WS_HEAD, WS_ZERO
  } wsel_t;

  typedef struct packed {
    logic       lwr;
    logic       enc_start;
    raddr_sel_t rsel;
    logic       a_ld;
    logic       n_set2;
    logic       lit_start;
    logic       n_inc;
    logic       back2;
    logic       v_ld;
    logic       p_shift;
    logic       rec_we;
    wsel_t      wsel;
    logic       at_add_n;
    logic       at_inc;
    logic       fin;
    logic       drain_out;
  } cmd_t;

  typedef struct packed {
    logic rec_ready;
    logic room;
    logic full_after;
    logic at_eq_w;
    logic at_eq_wm1;
    logic more;
    logic rd_eq_a;
    logic triple;
    logic cut_chk;
    logic look_eq;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/core/srle_in_if.sv @@
// ----------------------------------------------------------------------------
// srle_in_if: input word channel
// Push a pixel or request one record byte.
// ----------------------------------------------------------------------------
interface srle_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] pixel_index;

  modport source (output valid, operation, pixel_index, input ready);
  modport sink   (input valid, operation, pixel_index, output ready);
endinterface

@@ rtl/core/srle_out_if.sv @@
// ----------------------------------------------------------------------------
// srle_out_if: result word channel
// One record byte per read request.
// ----------------------------------------------------------------------------
interface srle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, out_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, out_byte, byte_valid, last_byte, output ready);
endinterface

@@ rtl/core/srle_ram.sv @@
// ----------------------------------------------------------------------------
// srle_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/srle_ctrl.sv @@
// ----------------------------------------------------------------------------
// srle_ctrl: encoder controller
// Sequences loading, packet encoding over the line store and draining.
// ----------------------------------------------------------------------------
module srle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  srle_pkg::status_t st,
  output srle_pkg::cmd_t    cmd
);
  srle_pkg::state_t state_r, state_nxt;
  logic             acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == srle_pkg::ST_IDLE) && !st.out_busy;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsel  = srle_pkg::RA_AT;
    cmd.wsel  = srle_pkg::WS_ZERO;
    unique case (state_r)
      srle_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_op == srle_pkg::OP_READ) begin
            state_nxt = srle_pkg::ST_RD;
          end else if (!st.rec_ready) begin
            cmd.lwr = st.room;
            // a dropped push (width lowered) also closes the line
            if (!st.room || st.full_after) begin
              cmd.enc_start = 1'b1;
              state_nxt     = srle_pkg::ST_TOP;
            end
          end
        end
      end
      srle_pkg::ST_RD: begin
        cmd.drain_out = 1'b1;
        state_nxt     = srle_pkg::ST_IDLE;
      end
      srle_pkg::ST_TOP: begin
        if (st.at_eq_w) begin
          state_nxt = srle_pkg::ST_TERM;
        end else begin
          cmd.rsel  = srle_pkg::RA_AT;
          state_nxt = srle_pkg::ST_A;
        end
      end
      srle_pkg::ST_A: begin
        cmd.a_ld = 1'b1;
        if (st.at_eq_wm1) begin
          state_nxt = srle_pkg::ST_S1;
        end else begin
          cmd.rsel  = srle_pkg::RA_AT1;
          state_nxt = srle_pkg::ST_B;
        end
      end
      srle_pkg::ST_S1: begin
        cmd.rec_we = 1'b1;
        cmd.wsel   = srle_pkg::WS_SINGLE;
        state_nxt  = srle_pkg::ST_S2;
      end
      srle_pkg::ST_S2: begin
        cmd.rec_we = 1'b1;
        cmd.wsel   = srle_pkg::WS_A;
        cmd.at_inc = 1'b1;
        state_nxt  = srle_pkg::ST_TOP;
      end
      srle_pkg::ST_B: begin
        if (st.rd_eq_a) begin
          cmd.n_set2 = 1'b1;
          state_nxt  = srle_pkg::ST_RCHK;
        end else begin
          cmd.lit_start = 1'b1;
          state_nxt     = srle_pkg::ST_LCHK;
        end
      end
      srle_pkg::ST_RCHK: begin
        if (st.more) begin
          cmd.rsel  = srle_pkg::RA_ATN;
          state_nxt = srle_pkg::ST_RCMP;
        end else begin
          state_nxt = srle_pkg::ST_RW1;
        end
      end
      srle_pkg::ST_RCMP: begin
        if (st.rd_eq_a) begin
          cmd.n_inc = 1'b1;
          state_nxt = srle_pkg::ST_RCHK;
        end else begin
          state_nxt = srle_pkg::ST_RW1;
        end
      end
      srle_pkg::ST_RW1: begin
        cmd.rec_we = 1'b1;
        cmd.wsel   = srle_pkg::WS_RUN;
        state_nxt  = srle_pkg::ST_RW2;
      end
      srle_pkg::ST_RW2: begin
        cmd.rec_we   = 1'b1;
        cmd.wsel     = srle_pkg::WS_A;
        cmd.at_add_n = 1'b1;
        state_nxt    = srle_pkg::ST_TOP;
      end
      srle_pkg::ST_LCHK: begin
        if (st.more) begin
          cmd.rsel  = srle_pkg::RA_ATN;
          state_nxt = srle_pkg::ST_LCMP;
        end else begin
          state_nxt = srle_pkg::ST_LHEAD;
        end
      end
      srle_pkg::ST_LCMP: begin
        if (st.triple) begin
          // three equal pixels: give back the pair already written
          cmd.back2 = 1'b1;
          state_nxt = srle_pkg::ST_LHEAD;
        end else if (st.cut_chk) begin
          cmd.v_ld  = 1'b1;
          cmd.rsel  = srle_pkg::RA_AT127;
          state_nxt = srle_pkg::ST_LLOOK;
        end else begin
          cmd.rec_we  = 1'b1;
          cmd.wsel    = srle_pkg::WS_PIX;
          cmd.n_inc   = 1'b1;
          cmd.p_shift = 1'b1;
          state_nxt   = srle_pkg::ST_LCHK;
        end
      end
      srle_pkg::ST_LLOOK: begin
        if (st.look_eq) begin
          state_nxt = srle_pkg::ST_LHEAD;
        end else begin
          cmd.rec_we = 1'b1;
          cmd.wsel   = srle_pkg::WS_V;
          cmd.n_inc  = 1'b1;
          state_nxt  = srle_pkg::ST_LCHK;
        end
      end
      srle_pkg::ST_LHEAD: begin
        cmd.rec_we   = 1'b1;
        cmd.wsel     = srle_pkg::WS_HEAD;
        cmd.at_add_n = 1'b1;
        state_nxt    = srle_pkg::ST_TOP;
      end
      srle_pkg::ST_TERM: begin
        cmd.rec_we = 1'b1;
        cmd.wsel   = srle_pkg::WS_ZERO;
        cmd.fin    = 1'b1;
        state_nxt  = srle_pkg::ST_IDLE;
      end
      default: state_nxt = srle_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ rtl/core/srle_dp.sv @@
// ----------------------------------------------------------------------------
// srle_dp: encoder datapath
// Line and record stores, position counters, compares and output register.
// ----------------------------------------------------------------------------
module srle_dp #(
  parameter int MAX_WIDTH    = srle_pkg::MAX_WIDTH_DEF,
  parameter int RECORD_DEPTH = srle_pkg::RECORD_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [srle_pkg::CFG_W-1:0] line_width,
  input  logic [7:0]               pixel_index,
  input  srle_pkg::cmd_t           cmd,
  output srle_pkg::status_t        st,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_byte,
  output logic                     byte_valid,
  output logic                     last_byte
);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int PW  = $clog2(2 * MAX_WIDTH + 3) + 1;
  localparam int LNW = $clog2(RECORD_DEPTH + 1);
  localparam int RAW = $clog2(RECORD_DEPTH);
  localparam int KW  = LNW + 1;

  logic [WW-1:0]  loaded_r, at_r, w;
  logic [6:0]     n_r;
  logic [PW-1:0]  pos_r, head_r;
  logic [LNW-1:0] len_r;
  logic [KW-1:0]  k_r;
  logic           rdy_r;
  logic [7:0]     a_r, v_r, p1_r, p2_r;
  logic           ov_r, obv_r, olast_r;
  logic [7:0]     obyte_r;

  logic [31:0]    lw32, w32, at32, atn32, ra32, wa32, pos1, len32, ks32;
  logic [AW-1:0]  l_raddr;
  logic [7:0]     lrd, rrd, wdata;
  logic [PW-1:0]  wa;
  logic           rwe;
  logic [7:0]     d_byte;
  logic           d_last;

  // effective width: zero acts as one, clamp at the store size
  assign lw32 = 32'(line_width);
  assign w32  = (lw32 == 32'd0) ? 32'd1 :
                ((lw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : lw32);
  assign w    = w32[WW-1:0];

  assign at32  = 32'(at_r);
  assign atn32 = at32 + 32'(n_r);

  always_comb begin
    case (cmd.rsel)
      srle_pkg::RA_AT:    ra32 = at32;
      srle_pkg::RA_AT1:   ra32 = at32 + 32'd1;
      srle_pkg::RA_ATN:   ra32 = atn32;
      srle_pkg::RA_AT127: ra32 = at32 + 32'(srle_pkg::MAX_PKT);
      default:            ra32 = at32;
    endcase
  end
  assign l_raddr = ra32[AW-1:0];

  srle_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (cmd.lwr),
    .waddr (loaded_r[AW-1:0]),
    .wdata (pixel_index),
    .raddr (l_raddr),
    .rdata (lrd)
  );

  always_comb begin
    case (cmd.wsel)
      srle_pkg::WS_SINGLE: wdata = srle_pkg::SINGLE_CODE;
      srle_pkg::WS_A:      wdata = a_r;
      srle_pkg::WS_RUN:    wdata = srle_pkg::RUN_FLAG | {1'b0, n_r};
      srle_pkg::WS_PIX:    wdata = lrd;
      srle_pkg::WS_V:      wdata = v_r;
      srle_pkg::WS_HEAD:   wdata = {1'b0, n_r};
      default:             wdata = 8'd0;
    endcase
  end
  assign wa   = (cmd.wsel == srle_pkg::WS_HEAD) ? head_r : pos_r;
  assign wa32 = 32'(wa);
  // bytes past the end of the store are dropped
  assign rwe  = cmd.rec_we && (wa32 < 32'(RECORD_DEPTH));
  assign ks32 = 32'(k_r) - 32'd2;

  srle_ram #(.WIDTH(8), .DEPTH(RECORD_DEPTH)) u_rec (
    .clk   (clk),
    .we    (rwe),
    .waddr (wa32[RAW-1:0]),
    .wdata (wdata),
    .raddr (ks32[RAW-1:0]),
    .rdata (rrd)
  );

  assign pos1  = 32'(pos_r) + 32'd1;
  assign len32 = 32'(len_r);

  always_comb begin
    if (k_r == KW'(0)) begin
      d_byte = len32[7:0];
    end else if (k_r == KW'(1)) begin
      d_byte = len32[15:8];
    end else begin
      d_byte = rrd;
    end
    d_last = (k_r > KW'(1)) && (32'(k_r) >= len32 + 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      rdy_r    <= 1'b0;
      len_r    <= '0;
      k_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cmd.lwr) begin
        loaded_r <= loaded_r + WW'(1);
      end
      if (cmd.fin) begin
        rdy_r <= 1'b1;
        len_r <= (pos1 > 32'(RECORD_DEPTH)) ? LNW'(RECORD_DEPTH) : pos1[LNW-1:0];
        k_r   <= '0;
      end
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      if (cmd.drain_out) begin
        ov_r <= 1'b1;
        if (rdy_r) begin
          if (d_last) begin
            rdy_r    <= 1'b0;
            loaded_r <= '0;
            k_r      <= '0;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc_start) begin
      at_r  <= '0;
      pos_r <= '0;
    end
    if (cmd.at_inc) begin
      at_r <= at_r + WW'(1);
    end
    if (cmd.at_add_n) begin
      at_r <= WW'(atn32);
    end
    if (cmd.rec_we && cmd.wsel != srle_pkg::WS_HEAD) begin
      pos_r <= pos_r + PW'(1);
    end
    if (cmd.lit_start) begin
      head_r <= pos_r;
      pos_r  <= pos_r + PW'(1);
      n_r    <= '0;
    end
    if (cmd.back2) begin
      pos_r <= pos_r - PW'(2);
      n_r   <= n_r - 7'd2;
    end
    if (cmd.n_set2) begin
      n_r <= 7'd2;
    end
    if (cmd.n_inc) begin
      n_r <= n_r + 7'd1;
    end
    if (cmd.a_ld) begin
      a_r <= lrd;
    end
    if (cmd.v_ld) begin
      v_r <= lrd;
    end
    if (cmd.p_shift) begin
      p2_r <= p1_r;
      p1_r <= lrd;
    end
    if (cmd.drain_out) begin
      obyte_r <= rdy_r ? d_byte : 8'd0;
      obv_r   <= rdy_r;
      olast_r <= rdy_r && d_last;
    end
  end

  assign st.rec_ready  = rdy_r;
  assign st.room       = loaded_r < w;
  assign st.full_after = (32'(loaded_r) + 32'd1) >= w32;
  assign st.at_eq_w    = (at_r == w);
  assign st.at_eq_wm1  = (at32 + 32'd1) == w32;
  assign st.more       = (atn32 < w32) && (n_r < 7'(srle_pkg::MAX_PKT));
  assign st.rd_eq_a    = (lrd == a_r);
  assign st.triple     = (n_r > 7'd2) && (lrd == p1_r) && (lrd == p2_r);
  assign st.cut_chk    = (n_r == 7'(srle_pkg::LIT_CUT)) &&
                         ((at32 + 32'(srle_pkg::MAX_PKT)) < w32);
  assign st.look_eq    = (v_r == lrd);
  assign st.out_busy   = ov_r;

  assign out_valid  = ov_r;
  assign out_byte   = obyte_r;
  assign byte_valid = obv_r;
  assign last_byte  = olast_r;

  a_fin_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> rdy_r)
    else $error("record not ready after encode");
  a_lwr_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lwr |-> (loaded_r < w) && !rdy_r)
    else $error("line store written past width");
  a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drain_out && rdy_r && d_last) |=> !rdy_r && (loaded_r == '0))
    else $error("drain end did not clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(obyte_r))
    else $error("result lost while stalled");
endmodule

@@ rtl/core/scanline_run_length_encoder.sv @@
// ----------------------------------------------------------------------------
// scanline_run_length_encoder: scanline RLE record builder
// Loads a line of palette indices, encodes it into a length-prefixed record,
// and drains that record one byte per read request.
// ----------------------------------------------------------------------------
//  port     | dir | handshake               | word
//  in_ch    | in  | valid/ready             | operation, pixel_index
//  out_ch   | out | valid/ready             | out_byte, byte_valid, last_byte
//  cfg_*    | in  | APB write, pready tied 1| line_width at byte address 0
//
//  A read passes through accept, the registered record store read and the
//  output register, where the result word is held until it is taken.
//  Encoding starts after the last pixel of a line or a dropped push; its pace
//  is set by the single line-store read port, and inputs are held off until
//  it ends.
//  No clearing pass after reset.
//  A waiting result blocks new input until it is taken.
// ----------------------------------------------------------------------------
module scanline_run_length_encoder #(
  parameter int MAX_WIDTH    = srle_pkg::MAX_WIDTH_DEF,
  parameter int RECORD_DEPTH = srle_pkg::RECORD_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  srle_in_if.sink                         in_ch,
  srle_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [srle_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [srle_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [srle_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  logic [srle_pkg::CFG_W-1:0] line_width_r;
  srle_pkg::cmd_t             cmd;
  srle_pkg::status_t          st;
  logic                       sel_lw;

  assign sel_lw     = (cfg_paddr[2] == srle_pkg::CFG_REG_LINE_WIDTH);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_lw ? srle_pkg::CFG_DATA_W'(line_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= srle_pkg::CFG_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_lw) begin
      line_width_r <= cfg_pwdata[srle_pkg::CFG_W-1:0];
    end
  end

  srle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  srle_dp #(.MAX_WIDTH(MAX_WIDTH), .RECORD_DEPTH(RECORD_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_width  (line_width_r),
    .pixel_index (in_ch.pixel_index),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .last_byte   (out_ch.last_byte)
  );
endmodule
